### hw/rtl/cpt_pkg.sv
// Shared types, constants and the sine sample function for the Clarke/Park transform unit.
`timescale 1ns / 1ps
`default_nettype none
package cpt_pkg;

	localparam int SINE_ENTRIES_DEF = 256;
	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
	localparam logic signed [17:0] INV_SQRT3_Q16 = 18'sd37837;
	localparam logic signed [17:0] SQRT3_HALF_Q16 = 18'sd56756;
	localparam int DUTY_STAGES = 4;
	localparam int DUTY_STEPS = 4;

	typedef enum logic {
		ACT_FORWARD = 1'b0,
		ACT_INVERSE = 1'b1
	} action_t;

	typedef struct packed {
		logic              flag;
		logic signed [15:0] value;
	} sat_t;

	function automatic sat_t sat16(input logic signed [39:0] v);
		sat_t r;
		if (v > 40'sd32767) begin
			r.flag = 1'b1;
			r.value = 16'sd32767;
		end else if (v < -40'sd32768) begin
			r.flag = 1'b1;
			r.value = -16'sd32768;
		end else begin
			r.flag = 1'b0;
			r.value = v[15:0];
		end
		return r;
	endfunction

	// Q1.15 sine of a Q32 turn fraction, quarter-wave series in Q30.
	function automatic logic signed [15:0] sine_entry(input logic [63:0] t32);
		logic [1:0]         quad;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        v;
		logic [63:0]        q15;
		logic signed [63:0] sum;
		quad = t32[31:30];
		x = ({34'd0, t32[29:0]} * PI_HALF_Q30) >> 30;
		if (quad[0]) begin
			x = PI_HALF_Q30 - x;
		end
		x2 = (x * x) >> 30;
		term = x;
		sum = $signed(x);
		term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd272; sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd342; sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd420; sum = sum + $signed(term);
		v = (sum < 0) ? 64'd0 : $unsigned(sum);
		q15 = (v + 64'd16384) >> 15;
		if (q15 > 64'd32767) begin
			q15 = 64'd32767;
		end
		return quad[1] ? -$signed(q15[15:0]) : $signed(q15[15:0]);
	endfunction

endpackage
`default_nettype wire

### hw/rtl/clarke_park_transform_unit.sv
// Top level of the Clarke/Park transform unit: valid pipeline, duty lanes and result select.
// The unit takes one request per clock unless the output stalls, and presents each result
// through ten register stages: the table lookup and the multiply chain of
// the transforms (five stages), then the duty divider (one setup stage and four stages of
// four quotient bits each). A stall on the output holds the whole pipeline, and a new
// request is taken whenever the output stage is empty or being drained. The sine table is
// a constant table, so no fill is needed.
`timescale 1ns / 1ps
`default_nettype none
module clarke_park_transform_unit import cpt_pkg::*; #(
	parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               action,
	input  wire logic [15:0]        rotor_angle,
	input  wire logic signed [15:0] phase_a_current,
	input  wire logic signed [15:0] phase_b_current,
	input  wire logic signed [15:0] volt_d,
	input  wire logic signed [15:0] volt_q,
	input  wire logic [15:0]        bus_voltage,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    result_kind,
	output logic signed [15:0]      current_d,
	output logic signed [15:0]      current_q,
	output logic signed [15:0]      volt_a,
	output logic signed [15:0]      volt_b,
	output logic signed [15:0]      volt_c,
	output logic [15:0]             duty_a,
	output logic [15:0]             duty_b,
	output logic [15:0]             duty_c,
	output logic                    saturated
);
	localparam int TAIL = DUTY_STAGES + 1;
	localparam int DEPTH = 5 + TAIL;

	logic [DEPTH-1:0] vld_q;
	logic             adv;

	assign adv = ~vld_q[DEPTH-1] | out_ready;
	assign in_ready = adv;
	assign out_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end

	logic               kind_s1;
	logic signed [15:0] ia_s1, ib_s1, vd_s1, vq_s1;
	logic [15:0]        bus_s1;
	logic signed [15:0] sin_s1, cos_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= action;
			ia_s1 <= phase_a_current;
			ib_s1 <= phase_b_current;
			vd_s1 <= volt_d;
			vq_s1 <= volt_q;
			bus_s1 <= bus_voltage;
		end
	end

	cpt_sine_lookup #(.SINE_ENTRIES(SINE_ENTRIES)) u_lookup (
		.clk(clk), .adv(adv), .rotor_angle(rotor_angle),
		.sin_s1(sin_s1), .cos_s1(cos_s1)
	);

	logic               kind_s5, sat_s5;
	logic [15:0]        bus_s5;
	logic signed [15:0] id_s5, iq_s5, va_s5, vb_s5, vc_s5;

	cpt_transform u_xform (
		.clk(clk), .adv(adv),
		.kind_s1(kind_s1), .ia_s1(ia_s1), .ib_s1(ib_s1), .vd_s1(vd_s1), .vq_s1(vq_s1),
		.bus_s1(bus_s1), .sin_s1(sin_s1), .cos_s1(cos_s1),
		.kind_s5(kind_s5), .bus_s5(bus_s5), .id_s5(id_s5), .iq_s5(iq_s5),
		.va_s5(va_s5), .vb_s5(vb_s5), .vc_s5(vc_s5), .sat_s5(sat_s5)
	);

	logic [15:0] da, db, dc;
	logic        sa, sb, sc;

	cpt_duty_div u_div_a (.clk(clk), .adv(adv), .volt(va_s5), .bus(bus_s5), .duty(da), .sat(sa));
	cpt_duty_div u_div_b (.clk(clk), .adv(adv), .volt(vb_s5), .bus(bus_s5), .duty(db), .sat(sb));
	cpt_duty_div u_div_c (.clk(clk), .adv(adv), .volt(vc_s5), .bus(bus_s5), .duty(dc), .sat(sc));

	logic               kind_t_s [TAIL];
	logic               sat_t_s  [TAIL];
	logic signed [15:0] id_t_s   [TAIL];
	logic signed [15:0] iq_t_s   [TAIL];
	logic signed [15:0] va_t_s   [TAIL];
	logic signed [15:0] vb_t_s   [TAIL];
	logic signed [15:0] vc_t_s   [TAIL];

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_t_s[0] <= kind_s5;
			sat_t_s[0] <= sat_s5;
			id_t_s[0] <= id_s5;
			iq_t_s[0] <= iq_s5;
			va_t_s[0] <= va_s5;
			vb_t_s[0] <= vb_s5;
			vc_t_s[0] <= vc_s5;
			for (int k = 1; k < TAIL; k++) begin
				kind_t_s[k] <= kind_t_s[k-1];
				sat_t_s[k] <= sat_t_s[k-1];
				id_t_s[k] <= id_t_s[k-1];
				iq_t_s[k] <= iq_t_s[k-1];
				va_t_s[k] <= va_t_s[k-1];
				vb_t_s[k] <= vb_t_s[k-1];
				vc_t_s[k] <= vc_t_s[k-1];
			end
		end
	end

	logic inv;
	assign inv = (kind_t_s[TAIL-1] == ACT_INVERSE);

	always_comb begin
		result_kind = kind_t_s[TAIL-1];
		current_d = inv ? 16'sd0 : id_t_s[TAIL-1];
		current_q = inv ? 16'sd0 : iq_t_s[TAIL-1];
		volt_a = inv ? va_t_s[TAIL-1] : 16'sd0;
		volt_b = inv ? vb_t_s[TAIL-1] : 16'sd0;
		volt_c = inv ? vc_t_s[TAIL-1] : 16'sd0;
		duty_a = inv ? da : 16'd0;
		duty_b = inv ? db : 16'd0;
		duty_c = inv ? dc : 16'd0;
		saturated = sat_t_s[TAIL-1] | (inv & (sa | sb | sc));
	end
endmodule
`default_nettype wire

### hw/rtl/cpt_sine_lookup.sv
// Sine table and registered sine/cosine lookup for one rotor angle.
`timescale 1ns / 1ps
`default_nettype none
module cpt_sine_lookup import cpt_pkg::*; #(
	parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
	input  wire logic               clk,
	input  wire logic               adv,
	input  wire logic [15:0]        rotor_angle,
	output logic signed [15:0]      sin_s1,
	output logic signed [15:0]      cos_s1
);
	localparam int IDX_W = $clog2(SINE_ENTRIES);
	localparam int PW = 16 + IDX_W;

	logic signed [15:0] sine_rom [SINE_ENTRIES];
	logic [PW-1:0]      prod;
	logic [IDX_W-1:0]   idx;
	logic [IDX_W:0]     csum;
	logic [IDX_W:0]     cwrap;
	logic [IDX_W-1:0]   cidx;

	for (genvar i = 0; i < SINE_ENTRIES; i++) begin : g_rom
		localparam logic [63:0] T32 = (64'(i) << 32) / 64'(SINE_ENTRIES);
		assign sine_rom[i] = sine_entry(T32);
	end

	always_comb begin
		prod = PW'(rotor_angle) * PW'(SINE_ENTRIES);
		idx = prod[PW-1:16];
		csum = {1'b0, idx} + (IDX_W+1)'(SINE_ENTRIES / 4);
		cwrap = (csum >= (IDX_W+1)'(SINE_ENTRIES)) ? csum - (IDX_W+1)'(SINE_ENTRIES) : csum;
		cidx = cwrap[IDX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sin_s1 <= sine_rom[idx];
			cos_s1 <= sine_rom[cidx];
		end
	end
endmodule
`default_nettype wire

### hw/rtl/cpt_transform.sv
// Clarke/Park and inverse Park/Clarke arithmetic, stages 2 through 5.
`timescale 1ns / 1ps
`default_nettype none
module cpt_transform import cpt_pkg::*; (
	input  wire logic               clk,
	input  wire logic               adv,
	input  wire logic               kind_s1,
	input  wire logic signed [15:0] ia_s1,
	input  wire logic signed [15:0] ib_s1,
	input  wire logic signed [15:0] vd_s1,
	input  wire logic signed [15:0] vq_s1,
	input  wire logic [15:0]        bus_s1,
	input  wire logic signed [15:0] sin_s1,
	input  wire logic signed [15:0] cos_s1,
	output logic                    kind_s5,
	output logic [15:0]             bus_s5,
	output logic signed [15:0]      id_s5,
	output logic signed [15:0]      iq_s5,
	output logic signed [15:0]      va_s5,
	output logic signed [15:0]      vb_s5,
	output logic signed [15:0]      vc_s5,
	output logic                    sat_s5
);
	// stage 2
	logic signed [17:0] sum_ab;
	logic signed [35:0] pf;
	logic signed [35:0] pfr;
	logic               kind_s2;
	logic [15:0]        bus_s2;
	logic signed [17:0] beta_f_s2;
	logic signed [15:0] ia_s2, sin_s2, cos_s2;
	logic signed [31:0] p_dc_s2, p_qs_s2, p_ds_s2, p_qc_s2;

	always_comb begin
		sum_ab = 18'(ia_s1) + (18'(ib_s1) <<< 1);
		pf = 36'(sum_ab) * 36'(INV_SQRT3_Q16);
		pfr = pf + 36'sd32768;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s2 <= kind_s1;
			bus_s2 <= bus_s1;
			beta_f_s2 <= pfr[33:16];
			ia_s2 <= ia_s1;
			sin_s2 <= sin_s1;
			cos_s2 <= cos_s1;
			p_dc_s2 <= vd_s1 * cos_s1;
			p_qs_s2 <= vq_s1 * sin_s1;
			p_ds_s2 <= vd_s1 * sin_s1;
			p_qc_s2 <= vq_s1 * cos_s1;
		end
	end

	// stage 3
	logic signed [32:0] al_sum, be_sum;
	logic               kind_s3;
	logic [15:0]        bus_s3;
	logic signed [33:0] f_bs_s3, f_ac_s3, f_bc_s3, f_as_s3;
	logic signed [17:0] alpha_s3, beta_s3;

	always_comb begin
		al_sum = 33'(p_dc_s2) - 33'(p_qs_s2) + 33'sd16384;
		be_sum = 33'(p_ds_s2) + 33'(p_qc_s2) + 33'sd16384;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s3 <= kind_s2;
			bus_s3 <= bus_s2;
			f_bs_s3 <= 34'(beta_f_s2) * 34'(sin_s2);
			f_ac_s3 <= 34'(ia_s2) * 34'(cos_s2);
			f_bc_s3 <= 34'(beta_f_s2) * 34'(cos_s2);
			f_as_s3 <= 34'(ia_s2) * 34'(sin_s2);
			alpha_s3 <= al_sum[32:15];
			beta_s3 <= be_sum[32:15];
		end
	end

	// stage 4
	logic signed [34:0] d_sum, q_sum;
	sat_t               d_sat, q_sat, a_sat;
	logic               kind_s4;
	logic [15:0]        bus_s4;
	logic signed [15:0] id_s4, iq_s4, va_s4;
	logic               satf_s4, sata_s4;
	logic signed [17:0] alpha_s4;
	logic signed [35:0] m_s4;

	always_comb begin
		d_sum = 35'(f_bs_s3) + 35'(f_ac_s3) + 35'sd16384;
		q_sum = 35'(f_bc_s3) - 35'(f_as_s3) + 35'sd16384;
		d_sat = sat16(40'(d_sum >>> 15));
		q_sat = sat16(40'(q_sum >>> 15));
		a_sat = sat16(40'(alpha_s3));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s4 <= kind_s3;
			bus_s4 <= bus_s3;
			id_s4 <= d_sat.value;
			iq_s4 <= q_sat.value;
			satf_s4 <= d_sat.flag | q_sat.flag;
			va_s4 <= a_sat.value;
			sata_s4 <= a_sat.flag;
			alpha_s4 <= alpha_s3;
			m_s4 <= 36'(beta_s3) * 36'(SQRT3_HALF_Q16);
		end
	end

	// stage 5
	logic signed [36:0] a_sh, b_sum, c_sum;
	sat_t               b_sat, c_sat;

	always_comb begin
		a_sh = 37'(alpha_s4) <<< 15;
		b_sum = -a_sh + 37'(m_s4) + 37'sd32768;
		c_sum = -a_sh - 37'(m_s4) + 37'sd32768;
		b_sat = sat16(40'(b_sum >>> 16));
		c_sat = sat16(40'(c_sum >>> 16));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s5 <= kind_s4;
			bus_s5 <= bus_s4;
			id_s5 <= id_s4;
			iq_s5 <= iq_s4;
			va_s5 <= va_s4;
			vb_s5 <= b_sat.value;
			vc_s5 <= c_sat.value;
			sat_s5 <= (kind_s4 == ACT_INVERSE) ? (sata_s4 | b_sat.flag | c_sat.flag) : satf_s4;
		end
	end
endmodule
`default_nettype wire

### hw/rtl/cpt_duty_div.sv
// Pipelined duty divider for one phase: (2v + bus) / (2 bus) in Q0.16 with clamping.
`timescale 1ns / 1ps
`default_nettype none
module cpt_duty_div import cpt_pkg::*; (
	input  wire logic               clk,
	input  wire logic               adv,
	input  wire logic signed [15:0] volt,
	input  wire logic [15:0]        bus,
	output logic [15:0]             duty,
	output logic                    sat
);
	logic signed [18:0] n;
	logic signed [18:0] dd;

	logic [16:0] rem_s  [DUTY_STAGES+1];
	logic [15:0] quo_s  [DUTY_STAGES+1];
	logic [15:0] bus_s  [DUTY_STAGES+1];
	logic        zero_s [DUTY_STAGES+1];
	logic        full_s [DUTY_STAGES+1];

	always_comb begin
		n = (19'(volt) <<< 1) + $signed({3'd0, bus});
		dd = $signed({2'd0, bus, 1'b0});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= n[16:0];
			quo_s[0] <= '0;
			bus_s[0] <= bus;
			zero_s[0] <= (bus == 16'd0) || (n < 0);
			full_s[0] <= (n >= dd);
		end
	end

	for (genvar k = 1; k <= DUTY_STAGES; k++) begin : g_stage
		logic [16:0] r;
		logic [17:0] t;
		logic [15:0] q;
		always_comb begin
			r = rem_s[k-1];
			q = quo_s[k-1];
			for (int j = 0; j < DUTY_STEPS; j++) begin
				t = {r, bus_s[k-1][16 - DUTY_STEPS*(k-1) - 1 - j]};
				if (t >= {1'b0, bus_s[k-1], 1'b0}) begin
					t = t - {1'b0, bus_s[k-1], 1'b0};
					q = {q[14:0], 1'b1};
				end else begin
					q = {q[14:0], 1'b0};
				end
				r = t[16:0];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k] <= r;
				quo_s[k] <= q;
				bus_s[k] <= bus_s[k-1];
				zero_s[k] <= zero_s[k-1];
				full_s[k] <= full_s[k-1];
			end
		end
	end

	always_comb begin
		sat = zero_s[DUTY_STAGES] | full_s[DUTY_STAGES];
		if (zero_s[DUTY_STAGES]) begin
			duty = 16'd0;
		end else if (full_s[DUTY_STAGES]) begin
			duty = 16'hFFFF;
		end else begin
			duty = quo_s[DUTY_STAGES];
		end
	end
endmodule
`default_nettype wire
